// ----- hdl/bpa_pkg.sv -----
// Package for the buddy page allocator: beat structs, operation and status codes,
// the memory entry layout and the sequencer state type. No dependencies.
`default_nettype none
package bpa_pkg;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_ADD   = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BAD = 2'd1;
  localparam logic [1:0] STAT_OOM = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] page_index;
    logic [3:0]  req_order;
    logic [12:0] region_frames;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_frame;
  } out_item_t;

  typedef struct packed {
    logic       head;
    logic [3:0] order;
  } frame_ent_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_FREE_EV,
    ST_CHKA,
    ST_CHKR,
    ST_ASCAN,
    ST_ATAKE,
    ST_SPLIT,
    ST_PF_CHK,
    ST_PF_EV,
    ST_ADD_NEXT,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/bpa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/buddy_page_allocator.sv -----
// Top level of the buddy page allocator: request sequencer around one frame memory.
// Depends on bpa_pkg and bpa_ram.
//
//   channel  direction  payload              handshake
//   in_      input      bpa_pkg::in_item_t   in_valid / in_ready
//   out_     output     bpa_pkg::out_item_t  out_valid / out_ready
//
// After reset a clearing pass writes every frame entry, with in_ready low.
// An allocate scans the frame memory for a free block of the selected order, then splits it down
// one order at a time. A free or add first checks ORDER_LIMIT aligned block heads, then scans its
// range one frame per cycle, then merges each inserted block with its free buddies order by order.
// A result waits in the output register while the next beat is accepted.
`default_nettype none
module buddy_page_allocator #(
  parameter int NUM_FRAMES  = 4096,
  parameter int ORDER_LIMIT = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bpa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bpa_pkg::out_item_t      out_data
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = ((FW > 16) ? FW : 16) + 2;
  localparam int LW = $clog2(ORDER_LIMIT);
  localparam logic [CW-1:0] NUM_C   = CW'(NUM_FRAMES);
  localparam logic [4:0]    LIMIT_C = 5'(ORDER_LIMIT);

  function automatic logic [CW-1:0] blk(input logic [4:0] k);
    blk = {{(CW-1){1'b0}}, 1'b1} << k;
  endfunction

  bpa_pkg::state_t    state_r, state_nxt;
  logic [FW:0]        clr_idx_r, clr_idx_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [CW-1:0]      first_r, first_nxt, count_r, count_nxt;
  logic [CW-1:0]      cur_r, cur_nxt, end_r, end_nxt;
  logic [4:0]         a_ord_r, a_ord_nxt, want_r, want_nxt, pf_ord_r, pf_ord_nxt;
  logic [CW-1:0]      gf_r, gf_nxt, pf_p_r, pf_p_nxt;
  logic [CW-1:0]      sc_idx_r, sc_idx_nxt, sc_len_r, sc_len_nxt, pend_idx_r, pend_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [CW-1:0]      res_g_r, res_g_nxt;
  logic [FW:0]        cnt_r [ORDER_LIMIT];
  logic [FW:0]        cnt_nxt [ORDER_LIMIT];
  logic               out_valid_r, out_valid_nxt;
  bpa_pkg::out_item_t out_data_r, out_data_nxt;

  logic               mem_we, mem_re;
  logic [FW-1:0]      mem_wa, mem_ra;
  logic [4:0]         mem_wd, mem_rd;
  bpa_pkg::frame_ent_t rd;

  logic [CW-1:0]      sc_addr, base_w, fr_w, rem_w, bud_w;
  logic               sc_match, sc_hit, sc_more, sc_done;
  logic [4:0]         asel, addk, rd_ord;
  logic               asel_found;

  bpa_ram #(.WIDTH(5), .DEPTH(NUM_FRAMES)) u_ram (
    .clk(clk), .we(mem_we), .wa(mem_wa), .wd(mem_wd),
    .re(mem_re), .ra(mem_ra), .rd(mem_rd)
  );

  assign rd     = bpa_pkg::frame_ent_t'(mem_rd);
  assign rd_ord = {1'b0, rd.order};
  assign base_w = CW'(in_data.page_index);
  assign fr_w   = CW'(in_data.region_frames);
  assign rem_w  = end_r - cur_r;
  assign bud_w  = pf_p_r ^ blk(pf_ord_r);

  always_comb begin
    asel       = '0;
    asel_found = 1'b0;
    for (int j = ORDER_LIMIT - 1; j >= 0; j--) begin
      if (5'(j) >= {1'b0, in_data.req_order} && cnt_r[j] != '0) begin
        asel       = 5'(j);
        asel_found = 1'b1;
      end
    end
  end

  always_comb begin
    addk = '0;
    for (int j = 0; j < ORDER_LIMIT; j++) begin
      if ((cur_r & (blk(5'(j)) - 1'b1)) == '0 && blk(5'(j)) <= rem_w) begin
        addk = 5'(j);
      end
    end
  end

  always_comb begin
    unique case (state_r)
      bpa_pkg::ST_CHKA: sc_addr = first_r & ~(blk(sc_idx_r[4:0]) - 1'b1);
      bpa_pkg::ST_CHKR: sc_addr = first_r + sc_idx_r;
      default:          sc_addr = sc_idx_r;
    endcase
    unique case (state_r)
      bpa_pkg::ST_CHKA: sc_match = rd.head && rd_ord == pend_idx_r[4:0];
      bpa_pkg::ST_CHKR: sc_match = rd.head;
      default:          sc_match = rd.head && rd_ord == a_ord_r;
    endcase
  end

  assign sc_hit  = pend_r && sc_match;
  assign sc_more = sc_idx_r < sc_len_r;
  assign sc_done = !sc_hit && !sc_more;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    op_nxt        = op_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    a_ord_nxt     = a_ord_r;
    want_nxt      = want_r;
    pf_ord_nxt    = pf_ord_r;
    gf_nxt        = gf_r;
    pf_p_nxt      = pf_p_r;
    sc_idx_nxt    = sc_idx_r;
    sc_len_nxt    = sc_len_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = 1'b0;
    res_st_nxt    = res_st_r;
    res_g_nxt     = res_g_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    in_ready      = 1'b0;

    if (state_r == bpa_pkg::ST_CHKA || state_r == bpa_pkg::ST_CHKR ||
        state_r == bpa_pkg::ST_ASCAN) begin
      if (sc_more && !sc_hit) begin
        mem_re       = 1'b1;
        mem_ra       = sc_addr[FW-1:0];
        sc_idx_nxt   = sc_idx_r + 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = sc_idx_r;
      end
    end

    unique case (state_r)
      bpa_pkg::ST_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r[FW-1:0];
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == (FW+1)'(NUM_FRAMES - 1)) begin
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_data.func;
          want_nxt   = {1'b0, in_data.req_order};
          res_g_nxt  = '0;
          res_st_nxt = bpa_pkg::STAT_BAD;
          state_nxt  = bpa_pkg::ST_FIN;
          sc_idx_nxt = '0;
          if (in_data.func == bpa_pkg::FUNC_ALLOC) begin
            if ({1'b0, in_data.req_order} >= LIMIT_C) begin
              res_st_nxt = bpa_pkg::STAT_BAD;
            end else if (!asel_found) begin
              res_st_nxt = bpa_pkg::STAT_OOM;
            end else begin
              a_ord_nxt  = asel;
              sc_len_nxt = NUM_C;
              state_nxt  = bpa_pkg::ST_ASCAN;
            end
          end else if (in_data.func == bpa_pkg::FUNC_FREE) begin
            if (base_w < NUM_C) begin
              mem_re    = 1'b1;
              mem_ra    = base_w[FW-1:0];
              first_nxt = base_w;
              state_nxt = bpa_pkg::ST_FREE_EV;
            end
          end else if (in_data.func == bpa_pkg::FUNC_ADD) begin
            if (fr_w != '0 && base_w < NUM_C && fr_w <= NUM_C - base_w) begin
              first_nxt  = base_w;
              count_nxt  = fr_w;
              sc_len_nxt = CW'(ORDER_LIMIT);
              state_nxt  = bpa_pkg::ST_CHKA;
            end
          end
        end
      end
      bpa_pkg::ST_FREE_EV: begin
        if (rd_ord >= LIMIT_C || (first_r & (blk(rd_ord) - 1'b1)) != '0 ||
            first_r + blk(rd_ord) > NUM_C) begin
          res_st_nxt = bpa_pkg::STAT_BAD;
          state_nxt  = bpa_pkg::ST_FIN;
        end else begin
          count_nxt  = blk(rd_ord);
          pf_ord_nxt = rd_ord;
          sc_idx_nxt = '0;
          sc_len_nxt = CW'(ORDER_LIMIT);
          state_nxt  = bpa_pkg::ST_CHKA;
        end
      end
      bpa_pkg::ST_CHKA: begin
        if (sc_hit) begin
          res_st_nxt = bpa_pkg::STAT_BAD;
          state_nxt  = bpa_pkg::ST_FIN;
        end else if (sc_done) begin
          sc_idx_nxt = '0;
          sc_len_nxt = count_r;
          state_nxt  = bpa_pkg::ST_CHKR;
        end
      end
      bpa_pkg::ST_CHKR: begin
        if (sc_hit) begin
          res_st_nxt = bpa_pkg::STAT_BAD;
          state_nxt  = bpa_pkg::ST_FIN;
        end else if (sc_done) begin
          if (op_r == bpa_pkg::FUNC_FREE) begin
            pf_p_nxt  = first_r;
            state_nxt = bpa_pkg::ST_PF_CHK;
          end else begin
            cur_nxt   = first_r;
            end_nxt   = first_r + count_r;
            state_nxt = bpa_pkg::ST_ADD_NEXT;
          end
        end
      end
      bpa_pkg::ST_ASCAN: begin
        if (sc_hit) begin
          gf_nxt    = pend_idx_r;
          state_nxt = bpa_pkg::ST_ATAKE;
        end else if (sc_done) begin
          res_st_nxt = bpa_pkg::STAT_OOM;
          state_nxt  = bpa_pkg::ST_FIN;
        end
      end
      bpa_pkg::ST_ATAKE: begin
        mem_we = 1'b1;
        mem_wa = gf_r[FW-1:0];
        mem_wd = {1'b0, want_r[3:0]};
        cnt_nxt[a_ord_r[LW-1:0]] = cnt_r[a_ord_r[LW-1:0]] - 1'b1;
        state_nxt = bpa_pkg::ST_SPLIT;
      end
      bpa_pkg::ST_SPLIT: begin
        if (a_ord_r > want_r) begin
          a_ord_nxt  = a_ord_r - 1'b1;
          pf_ord_nxt = a_ord_r - 1'b1;
          pf_p_nxt   = gf_r ^ blk(a_ord_r - 1'b1);
          state_nxt  = bpa_pkg::ST_PF_CHK;
        end else begin
          res_st_nxt = bpa_pkg::STAT_OK;
          res_g_nxt  = gf_r;
          state_nxt  = bpa_pkg::ST_FIN;
        end
      end
      bpa_pkg::ST_PF_CHK, bpa_pkg::ST_PF_EV: begin
        if (state_r == bpa_pkg::ST_PF_CHK && pf_ord_r + 1'b1 < LIMIT_C && bud_w < NUM_C) begin
          mem_re    = 1'b1;
          mem_ra    = bud_w[FW-1:0];
          state_nxt = bpa_pkg::ST_PF_EV;
        end else if (state_r == bpa_pkg::ST_PF_EV && rd.head && rd_ord == pf_ord_r) begin
          mem_we = 1'b1;
          mem_wa = bud_w[FW-1:0];
          mem_wd = {1'b0, rd.order};
          cnt_nxt[pf_ord_r[LW-1:0]] = cnt_r[pf_ord_r[LW-1:0]] - 1'b1;
          pf_p_nxt   = (bud_w < pf_p_r) ? bud_w : pf_p_r;
          pf_ord_nxt = pf_ord_r + 1'b1;
          state_nxt  = bpa_pkg::ST_PF_CHK;
        end else begin
          mem_we = 1'b1;
          mem_wa = pf_p_r[FW-1:0];
          mem_wd = {1'b1, pf_ord_r[3:0]};
          cnt_nxt[pf_ord_r[LW-1:0]] = cnt_r[pf_ord_r[LW-1:0]] + 1'b1;
          if (op_r == bpa_pkg::FUNC_ADD) begin
            state_nxt = bpa_pkg::ST_ADD_NEXT;
          end else if (op_r == bpa_pkg::FUNC_FREE) begin
            res_st_nxt = bpa_pkg::STAT_OK;
            state_nxt  = bpa_pkg::ST_FIN;
          end else begin
            state_nxt = bpa_pkg::ST_SPLIT;
          end
        end
      end
      bpa_pkg::ST_ADD_NEXT: begin
        if (cur_r < end_r) begin
          pf_p_nxt   = cur_r;
          pf_ord_nxt = addk;
          cur_nxt    = cur_r + blk(addk);
          state_nxt  = bpa_pkg::ST_PF_CHK;
        end else begin
          res_st_nxt = bpa_pkg::STAT_OK;
          state_nxt  = bpa_pkg::ST_FIN;
        end
      end
      bpa_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_st_r;
          out_data_nxt.granted_frame = res_g_r[11:0];
          state_nxt                  = bpa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_CLR;
      clr_idx_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < ORDER_LIMIT; j++) begin
        cnt_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    first_r    <= first_nxt;
    count_r    <= count_nxt;
    cur_r      <= cur_nxt;
    end_r      <= end_nxt;
    a_ord_r    <= a_ord_nxt;
    want_r     <= want_nxt;
    pf_ord_r   <= pf_ord_nxt;
    gf_r       <= gf_nxt;
    pf_p_r     <= pf_p_nxt;
    sc_idx_r   <= sc_idx_nxt;
    sc_len_r   <= sc_len_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_st_r   <= res_st_nxt;
    res_g_r    <= res_g_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::ST_IDLE |-> !mem_we)
    else $error("frame memory written while idle");

  a_unknown_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == bpa_pkg::FUNC_NONE |=> state_r == bpa_pkg::ST_FIN)
    else $error("unknown operation did not finish at once");

  a_take_counted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::ST_ATAKE |-> cnt_r[a_ord_r[LW-1:0]] != '0)
    else $error("block taken from an order with no free blocks");

endmodule
`default_nettype wire
